// ----- sv/hsfd_pkg.sv -----
package hsfd_pkg;

  // CRC-8 of the sensor: polynomial 0x31, seed 0xFF, MSB first, no final XOR
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Frame layout: T msb, T lsb, T crc, H msb, H lsb, H crc
  localparam int unsigned FRAME_BYTES = 6;
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_T_MSB = 3'd0;
  localparam logic [POS_W-1:0] POS_T_LSB = 3'd1;
  localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
  localparam logic [POS_W-1:0] POS_H_MSB = 3'd3;
  localparam logic [POS_W-1:0] POS_H_LSB = 3'd4;
  localparam logic [POS_W-1:0] POS_H_CRC = 3'(FRAME_BYTES - 1);

  // Scaling constants
  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_BAD = 2'd1,
    ST_HUM_BAD  = 2'd2
  } status_e;

  // One checked frame, ready to be scaled
  typedef struct packed {
    status_e     status;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
  } hsfd_job_t;

  // Feed one byte through the CRC, one bit per step
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] acc;
    acc = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (acc[7]) begin
        acc = {acc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // floor(x / 65535) for x below 2^31: x = a*2^16 + b = a*65535 + (a + b),
  // and a + b stays below twice the divisor
  function automatic logic [15:0] div_full_scale(input logic [31:0] x);
    logic [16:0] rem;
    rem = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    return x[31:16] + ((rem >= {1'b0, FULL_SCALE}) ? 16'd1 : 16'd0);
  endfunction

endpackage

// ----- sv/hsfd_front.sv -----
module hsfd_front import hsfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic      start_i,
  output logic      byte_ready_o,
  output logic      push_o,
  output hsfd_job_t job_o,
  input  logic      queue_full_i
);

  logic [POS_W-1:0] pos_q, pos_d, pos_cur;
  logic [7:0]       crc_q, crc_d;
  logic [15:0]      word_q, word_d;
  logic [15:0]      raw_temp_q, raw_temp_d;
  logic             temp_bad_q, temp_bad_d;
  logic             take;

  assign byte_ready_o = !queue_full_i;
  assign take = byte_valid_i && byte_ready_o;

  // Resolve the byte position: a start mark or an out-of-range value restarts
  always_comb begin
    pos_cur = start_i ? POS_T_MSB : pos_q;
    if (pos_cur > POS_H_CRC) begin
      pos_cur = POS_T_MSB;
    end
  end

  // Classify the byte and update the frame state
  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    word_d     = word_q;
    raw_temp_d = raw_temp_q;
    temp_bad_d = temp_bad_q;
    push_o     = 1'b0;
    job_o.status   = ST_OK;
    job_o.raw_temp = raw_temp_q;
    job_o.raw_hum  = word_q;
    if (take) begin
      unique case (pos_cur)
        POS_T_MSB, POS_H_MSB: begin
          crc_d  = crc8_feed(CRC_INIT, byte_i);
          word_d = {byte_i, 8'h00};
          pos_d  = pos_cur + 3'd1;
        end
        POS_T_LSB, POS_H_LSB: begin
          crc_d  = crc8_feed(crc_q, byte_i);
          word_d = word_q | {8'h00, byte_i};
          pos_d  = pos_cur + 3'd1;
        end
        POS_T_CRC: begin
          temp_bad_d = (crc_q != byte_i);
          raw_temp_d = word_q;
          crc_d      = CRC_INIT;
          pos_d      = POS_H_MSB;
        end
        default: begin
          push_o = 1'b1;
          if (temp_bad_q) begin
            job_o.status = ST_TEMP_BAD;
          end else if (crc_q != byte_i) begin
            job_o.status = ST_HUM_BAD;
          end
          crc_d = CRC_INIT;
          pos_d = POS_T_MSB;
        end
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_T_MSB;
      crc_q      <= CRC_INIT;
      word_q     <= '0;
      raw_temp_q <= '0;
      temp_bad_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      word_q     <= word_d;
      raw_temp_q <= raw_temp_d;
      temp_bad_q <= temp_bad_d;
    end
  end

endmodule

// ----- sv/hsfd_queue.sv -----
module hsfd_queue import hsfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hsfd_job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  output hsfd_job_t job_o,
  input  logic      pop_i
);

  hsfd_job_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/hsfd_back.sv -----
module hsfd_back import hsfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  hsfd_job_t   job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output status_e     status_o,
  output logic [14:0] temp_o,
  output logic [13:0] hum_o
);

  // Stage 1: products
  logic        s1_valid_q;
  status_e     s1_status_q;
  logic [31:0] s1_temp_prod_q, s1_hum_prod_q;
  logic        s1_ready;

  // Stage 2: output register and last good values
  logic        out_valid_q;
  status_e     out_status_q;
  logic [14:0] out_temp_q, last_temp_q;
  logic [13:0] out_hum_q, last_hum_q;
  logic        out_take;

  logic [15:0]        temp_quo, hum_quo;
  logic signed [15:0] temp_wide;
  logic [14:0]        temp_new;
  logic [13:0]        hum_new;

  assign out_take = !out_valid_q || out_ready_i;
  assign s1_ready = !s1_valid_q || out_take;
  assign pop_o    = job_valid_i && s1_ready;

  // Multiply raw words by their full-scale span
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_status_q    <= job_i.status;
      s1_temp_prod_q <= {17'd0, TEMP_SCALE} * {16'd0, job_i.raw_temp};
      s1_hum_prod_q  <= {18'd0, HUM_SCALE} * {16'd0, job_i.raw_hum};
    end
  end

  // Divide by 65535 and offset the temperature
  always_comb begin
    temp_quo  = div_full_scale(s1_temp_prod_q);
    hum_quo   = div_full_scale(s1_hum_prod_q);
    temp_wide = $signed({1'b0, temp_quo[14:0]}) + TEMP_OFFSET;
    temp_new  = temp_wide[14:0];
    hum_new   = hum_quo[13:0];
  end

  // Load result; keep last good values on a CRC error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_temp_q <= '0;
      last_hum_q  <= '0;
    end else begin
      if (out_take) begin
        out_valid_q <= s1_valid_q;
      end
      if (out_take && s1_valid_q && s1_status_q == ST_OK) begin
        last_temp_q <= temp_new;
        last_hum_q  <= hum_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_valid_q) begin
      out_status_q <= s1_status_q;
      if (s1_status_q == ST_OK) begin
        out_temp_q <= temp_new;
        out_hum_q  <= hum_new;
      end else begin
        out_temp_q <= last_temp_q;
        out_hum_q  <= last_hum_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign temp_o      = out_temp_q;
  assign hum_o       = out_hum_q;

endmodule

// ----- sv/humidity_sensor_frame_decoder.sv -----
// Channel  Dir  Handshake               Payload
// s_axis   in   tvalid/tready, 1/cycle  tdata: data_byte; tuser: frame_start
// m_axis   out  tvalid/tready           tuser: status; tdata: temp, humidity
//
// One byte is taken per cycle while the job queue is not full. The sixth byte of a
// frame is classified and written to the job queue on the edge that takes it; its
// result passes the multiply stage, then the divide-and-load output register.
// A two-entry job queue sits between the byte front end and the scaling
// back end, so input stalls only once both queue entries are taken.
// Reset is asynchronous, active low, and restarts the frame at byte 0.
module humidity_sensor_frame_decoder import hsfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [14:0] temperature_centi, [28:15] humidity_centi
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  logic        push, queue_full, job_valid, pop;
  hsfd_job_t   push_job, pop_job;
  status_e     status;
  logic [14:0] temp;
  logic [13:0] hum;

  hsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_i       (s_axis_tdata_i),
    .start_i      (s_axis_tuser_i),
    .byte_ready_o (s_axis_tready_o),
    .push_o       (push),
    .job_o        (push_job),
    .queue_full_i (queue_full)
  );

  hsfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (queue_full),
    .valid_o (job_valid),
    .job_o   (pop_job),
    .pop_i   (pop)
  );

  hsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_o    (status),
    .temp_o      (temp),
    .hum_o       (hum)
  );

  // Pack result item
  assign m_axis_tdata_o = {3'b000, hum, temp};
  assign m_axis_tuser_o = status;

endmodule

// ----- tb/sv/tb_humidity_sensor_frame_decoder.sv -----
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decoder;
  import hsfd_pkg::*;

  // One decoded measurement as it leaves the block
  typedef struct packed {
    status_e            st;
    logic signed [14:0] temp;
    logic [13:0]        hum;
  } meas_t;

  // Directed stimulus row; typed marks a row whose result is written out by hand
  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       typed;
    meas_t      m;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;
  localparam int unsigned ITEM_TARGET = 1650;

  // Frames: both CRCs bad before any good frame, all-zero words, all-one words
  // without a start mark, a stray byte, then a resync with a bad humidity CRC
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b1, '{ST_TEMP_BAD, 15'sd0, 14'd0}},
    '{8'h00, 1'b1, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h81, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h81, 1'b0, 1'b1, '{ST_OK, -15'sd4500, 14'd0}},
    '{8'hFF, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hFF, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hAC, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hFF, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hFF, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hAC, 1'b0, 1'b1, '{ST_OK, 15'sd13000, 14'd10000}},
    '{8'h55, 1'b1, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hBE, 1'b1, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hEF, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h92, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hFF, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'hFF, 1'b0, 1'b0, '{ST_OK, 15'sd0, 14'd0}},
    '{8'h00, 1'b0, 1'b1, '{ST_HUM_BAD, 15'sd13000, 14'd10000}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  humidity_sensor_frame_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Decoder mirror state
  logic [2:0]         frame_pos = POS_T_MSB;
  logic [7:0]         crc_run = CRC_INIT;
  logic [15:0]        word_acc = '0;
  logic [15:0]        temp_raw_keep = '0;
  logic               temp_crc_fail = 1'b0;
  logic signed [14:0] good_temp = '0;
  logic [13:0]        good_hum = '0;

  meas_t pending_meas[$];
  int    n_sent = 0;
  int    n_err = 0;
  int    n_ok = 0;
  int    n_tbad = 0;
  int    n_hbad = 0;
  int    burst_left = 0;
  bit    need_sof = 1'b1;
  bit    pause_done = 1'b0;

  // CRC-8 of one byte, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] seed, input logic [7:0] d);
    logic [7:0] r;
    r = seed ^ d;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] crc_word(input logic [15:0] w);
    return crc_byte(crc_byte(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advance the mirror by one byte; got is set on the sixth byte of a frame
  task automatic decode_byte(input logic [7:0] b, input logic sof,
                             output logic got, output meas_t m);
    logic [2:0]  p;
    logic [31:0] rt;
    logic [31:0] rh;
    logic        hum_fail;
    got = 1'b0;
    m = '0;
    p = sof ? POS_T_MSB : frame_pos;
    if (p > POS_H_CRC) p = POS_T_MSB;
    case (p)
      POS_T_MSB, POS_H_MSB: begin
        crc_run = crc_byte(CRC_INIT, b);
        word_acc = {b, 8'h00};
        frame_pos = 3'(p + 1);
      end
      POS_T_LSB, POS_H_LSB: begin
        crc_run = crc_byte(crc_run, b);
        word_acc = word_acc | {8'h00, b};
        frame_pos = 3'(p + 1);
      end
      POS_T_CRC: begin
        temp_crc_fail = (crc_run != b);
        temp_raw_keep = word_acc;
        crc_run = CRC_INIT;
        frame_pos = POS_H_MSB;
      end
      default: begin
        hum_fail = (crc_run != b);
        if (temp_crc_fail) begin
          m.st = ST_TEMP_BAD;
        end else if (hum_fail) begin
          m.st = ST_HUM_BAD;
        end else begin
          m.st = ST_OK;
          rt = {16'h0000, temp_raw_keep};
          rh = {16'h0000, word_acc};
          good_temp = 15'(-4500 + int'((32'd17500 * rt) / 32'd65535));
          good_hum = 14'((32'd10000 * rh) / 32'd65535);
        end
        m.temp = good_temp;
        m.hum = good_hum;
        crc_run = CRC_INIT;
        frame_pos = POS_T_MSB;
        got = 1'b1;
      end
    endcase
  endtask

  // Drop valid for a random gap once the current burst runs out
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
    end
  endtask

  // Offer one byte, hold until taken, then log what it should produce
  task automatic send_item(input logic [7:0] b, input logic sof,
                           input logic typed, input meas_t tm);
    logic  got;
    meas_t pm;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= sof;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_byte(b, sof, got, pm);
    if (got) pending_meas.push_back(typed ? tm : pm);
    n_sent++;
    pace_sender();
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(16'hFFFF - $urandom_range(0, 7));
      3: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // One random frame: mostly well formed, some with bad CRCs, cut short, or noise
  task automatic send_frame();
    logic [7:0] fb [6];
    logic [15:0] tw;
    logic [15:0] hw;
    int kind;
    int cnt;
    logic sof;
    tw = pick_raw();
    hw = pick_raw();
    fb[0] = tw[15:8];
    fb[1] = tw[7:0];
    fb[2] = crc_word(tw);
    fb[3] = hw[15:8];
    fb[4] = hw[7:0];
    fb[5] = crc_word(hw);
    kind = $urandom_range(0, 99);
    if ((kind >= 70 && kind < 78) || (kind >= 86 && kind < 89))
      fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
    if (kind >= 78 && kind < 89)
      fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
    sof = need_sof ? 1'b1 : 1'($urandom_range(0, 1));
    if (kind >= 95) begin
      cnt = $urandom_range(1, 7);
      repeat (cnt) send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
      need_sof = 1'b1;
    end else begin
      cnt = (kind >= 89) ? $urandom_range(1, 5) : 6;
      for (int i = 0; i < cnt; i++) send_item(fb[i], (i == 0) ? sof : 1'b0, 1'b0, '0);
      need_sof = (cnt != 6);
    end
  endtask

  // Receiver: random ready pattern, one long hold once results are flowing
  int  hold_left = 0;
  bit  long_done = 1'b0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!long_done && (n_ok + n_tbad + n_hbad) >= 60) begin
      long_done = 1'b1;
      hold_left = 150;
      m_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          m_tready <= 1'b1;
          hold_left = $urandom_range(0, 29);
        end
        6, 7, 8: begin
          m_tready <= 1'b0;
          hold_left = $urandom_range(0, 7);
        end
        default: begin
          m_tready <= 1'b1;
          hold_left = 80;
        end
      endcase
    end
  end

  // Compare each delivered measurement with the oldest pending one
  always @(posedge clk_i) begin : result_check
    meas_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_meas.size() == 0) begin
        $error("measurement with no frame pending: status %0d temp %0d hum %0d",
               m_axis_tuser_o, $signed(m_axis_tdata_o[14:0]), m_axis_tdata_o[28:15]);
        n_err++;
      end else begin
        want = pending_meas.pop_front();
        if (m_axis_tuser_o != want.st) begin
          $error("status: expected %0d, actual %0d", want.st, m_axis_tuser_o);
          n_err++;
        end
        if (m_axis_tdata_o[14:0] != want.temp) begin
          $error("temperature_centi: expected %0d, actual %0d", want.temp,
                 $signed(m_axis_tdata_o[14:0]));
          n_err++;
        end
        if (m_axis_tdata_o[28:15] != want.hum) begin
          $error("humidity_centi: expected %0d, actual %0d", want.hum,
                 m_axis_tdata_o[28:15]);
          n_err++;
        end
        case (want.st)
          ST_OK:       n_ok++;
          ST_TEMP_BAD: n_tbad++;
          default:     n_hbad++;
        endcase
      end
    end
  end

  // Main sequence: reset, directed rows, random frames with a drain pause midway, drain
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIR_TAB[i].data, DIR_TAB[i].sof, DIR_TAB[i].typed, DIR_TAB[i].m);
    while (n_sent < ITEM_TARGET) begin
      if (!pause_done && n_sent >= ITEM_TARGET / 2) begin
        // hold off until the block has delivered everything
        pause_done = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_meas.size() != 0) @(posedge clk_i);
      end
      send_frame();
    end
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_meas.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes; checked %0d good, %0d temperature-CRC and %0d humidity-CRC frames",
             n_sent, n_ok, n_tbad, n_hbad);
    $display("with resyncs, truncated frames, noise, a long output hold and a drain pause");
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hsfd_pkg.sv
sv/hsfd_front.sv
sv/hsfd_queue.sv
sv/hsfd_back.sv
sv/humidity_sensor_frame_decoder.sv
tb/sv/tb_humidity_sensor_frame_decoder.sv
